@@ rtl/rc5_block_mixer_macros.svh @@
// Assertion macros for the RC5 block mixer.
// Used by the top level only; no other dependencies.
`ifndef RC5_BLOCK_MIXER_MACROS_SVH
`define RC5_BLOCK_MIXER_MACROS_SVH
`ifndef ASSERT_OFF
`define RC5BM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define RC5BM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define RC5BM_ASSERT(lbl, prop, msg)
`define RC5BM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/rc5bm_pkg.sv @@
// Shared types, constants and rotate functions for the RC5 block mixer.
// No dependencies.
package rc5bm_pkg;

    typedef logic [31:0] t_word;

    typedef enum logic {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } t_op;

    typedef struct packed {
        logic vld;
        t_op  op;
    } t_ctl;

    typedef enum logic [1:0] {
        EXP_X,
        EXP_Y,
        EXP_DONE
    } t_exp_state;

    localparam t_word MAGIC_P = 32'hb7e15163;
    localparam t_word MAGIC_Q = 32'h9e3779b9;

    function automatic t_word rotl32(input t_word v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} << n;
        return d[63:32];
    endfunction

    function automatic t_word rotr32(input t_word v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} >> n;
        return d[31:0];
    endfunction

endpackage

@@ rtl/rc5bm_expand.sv @@
// Keyless round table expansion, run once after reset.
// Depends on rc5bm_pkg; the table rotates as a shift line, each mixing step passing through EXP_X and then EXP_Y.
module rc5bm_expand import rc5bm_pkg::*; #(
    parameter int TABLE_LEN = 12
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    output t_word o_table [TABLE_LEN],
    output logic  o_ready
);

    localparam int STEPS = 3 * TABLE_LEN;
    localparam int CW    = $clog2(STEPS);
    localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

    t_exp_state      r_state, n_state;
    t_word           r_tab [TABLE_LEN];
    t_word           n_tab [TABLE_LEN];
    t_word           r_x, n_x;
    t_word           r_y, n_y;
    logic [CW-1:0]   r_k, n_k;
    t_word           w_sum;

    assign w_sum = r_x + r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EXP_X;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_tab   = r_tab;
        unique case (r_state)
            EXP_X: begin
                n_x     = rotl32(r_tab[0] + r_x + r_y, 5'd3);
                n_state = EXP_Y;
            end
            EXP_Y: begin
                for (int j = 0; j < TABLE_LEN - 1; j++) begin
                    n_tab[j] = r_tab[j+1];
                end
                n_tab[TABLE_LEN-1] = r_x;
                n_y = rotl32(w_sum, w_sum[4:0]);
                n_k = r_k + CW'(1);
                n_state = (r_k == LAST) ? EXP_DONE : EXP_X;
            end
            EXP_DONE: begin
                n_state = EXP_DONE;
            end
            default: begin
                n_state = EXP_X;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_k <= '0;
            for (int j = 0; j < TABLE_LEN; j++) begin
                r_tab[j] <= MAGIC_P + MAGIC_Q * 32'(j);
            end
        end else begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_k   <= n_k;
            r_tab <= n_tab;
        end
    end

    assign o_table = r_tab;
    assign o_ready = (r_state == EXP_DONE);

endmodule

@@ rtl/rc5bm_half.sv @@
// One half-round pipeline stage: updates one word, forward for encrypt and reversed for decrypt.
// Depends on rc5bm_pkg.
module rc5bm_half import rc5bm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_odd,
    input  t_word i_s_enc,
    input  t_word i_s_dec,
    input  t_ctl  i_ctl,
    input  t_word i_a,
    input  t_word i_b,
    output t_ctl  o_ctl,
    output t_word o_a,
    output t_word o_b
);

    t_ctl  r_ctl;
    t_word r_a, r_b;
    t_word n_a, n_b;

    always_comb begin
        n_a = i_a;
        n_b = i_b;
        unique case ({i_ctl.op, i_odd})
            {OP_ENC, 1'b0}: n_a = rotl32(i_a ^ i_b, i_b[4:0]) + i_s_enc;
            {OP_ENC, 1'b1}: n_b = rotl32(i_b ^ i_a, i_a[4:0]) + i_s_enc;
            {OP_DEC, 1'b0}: n_b = rotr32(i_b - i_s_dec, i_a[4:0]) ^ i_a;
            {OP_DEC, 1'b1}: n_a = rotr32(i_a - i_s_dec, i_b[4:0]) ^ i_b;
            default: begin
                n_a = i_a;
                n_b = i_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;

endmodule

@@ rtl/rc5bm_trim.sv @@
// Whitening stage: adds the first two table words on entry for encrypt,
// or subtracts them on exit for decrypt. Depends on rc5bm_pkg.
module rc5bm_trim import rc5bm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_exit,
    input  t_word i_s_lo,
    input  t_word i_s_hi,
    input  t_ctl  i_ctl,
    input  t_word i_a,
    input  t_word i_b,
    output t_ctl  o_ctl,
    output t_word o_a,
    output t_word o_b
);

    t_ctl  r_ctl;
    t_word r_a, r_b;
    t_word n_a, n_b;
    logic  w_apply;

    assign w_apply = ((i_ctl.op == OP_DEC) == i_exit);

    always_comb begin
        n_a = i_a;
        n_b = i_b;
        if (w_apply && i_exit) begin
            n_a = i_a - i_s_lo;
            n_b = i_b - i_s_hi;
        end else if (w_apply) begin
            n_a = i_a + i_s_lo;
            n_b = i_b + i_s_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;

endmodule

@@ rtl/rc5_block_mixer.sv @@
// Top level of the keyless RC5-32 block mixer: table expansion and the round pipeline.
// Depends on rc5bm_pkg, rc5bm_expand, rc5bm_trim, rc5bm_half and the assertion macros.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_op, i_block_in
//   output   out        o_valid / i_stall   o_block_out
//
// One block is accepted per cycle once the table is ready and the output is not stalled; the pipeline has
// one register stage for each half-round plus an entry and an exit whitening stage.
// After reset the table expansion runs each mixing step through EXP_X and then EXP_Y,
// and o_stall stays high until it completes.
// A stall on a valid output freezes the whole pipeline, so nothing is lost or repeated.
`include "rc5_block_mixer_macros.svh"
module rc5_block_mixer import rc5bm_pkg::*; #(
    parameter int ROUNDS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [63:0] i_block_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_block_out
);

    localparam int TABLE_LEN = 2 * (ROUNDS + 1);
    localparam int HALVES    = 2 * ROUNDS;
    localparam int N         = HALVES + 2;

    t_word w_tab [TABLE_LEN];
    logic  w_ready;
    logic  w_adv;
    t_ctl  w_ctl [N+1];
    t_word w_a   [N+1];
    t_word w_b   [N+1];

    rc5bm_expand #(
        .TABLE_LEN (TABLE_LEN)
    ) u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_table (w_tab),
        .o_ready (w_ready)
    );

    assign w_adv   = !w_ctl[N].vld || !i_stall;
    assign o_stall = !w_ready || !w_adv;

    assign w_ctl[0].vld = i_valid && w_ready;
    assign w_ctl[0].op  = t_op'(i_op);
    assign w_a[0]       = i_block_in[31:0];
    assign w_b[0]       = i_block_in[63:32];

    rc5bm_trim u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_exit  (1'b0),
        .i_s_lo  (w_tab[0]),
        .i_s_hi  (w_tab[1]),
        .i_ctl   (w_ctl[0]),
        .i_a     (w_a[0]),
        .i_b     (w_b[0]),
        .o_ctl   (w_ctl[1]),
        .o_a     (w_a[1]),
        .o_b     (w_b[1])
    );

    for (genvar h = 0; h < HALVES; h++) begin : g_half
        rc5bm_half u_half (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_odd   (1'(h % 2)),
            .i_s_enc (w_tab[2 + h]),
            .i_s_dec (w_tab[HALVES + 1 - h]),
            .i_ctl   (w_ctl[h+1]),
            .i_a     (w_a[h+1]),
            .i_b     (w_b[h+1]),
            .o_ctl   (w_ctl[h+2]),
            .o_a     (w_a[h+2]),
            .o_b     (w_b[h+2])
        );
    end

    rc5bm_trim u_exit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_exit  (1'b1),
        .i_s_lo  (w_tab[0]),
        .i_s_hi  (w_tab[1]),
        .i_ctl   (w_ctl[N-1]),
        .i_a     (w_a[N-1]),
        .i_b     (w_b[N-1]),
        .o_ctl   (w_ctl[N]),
        .o_a     (w_a[N]),
        .o_b     (w_b[N])
    );

    assign o_valid     = w_ctl[N].vld;
    assign o_block_out = {w_b[N], w_a[N]};

    `RC5BM_ASSERT(a_ready_sticks, w_ready |=> w_ready, "table ready dropped after expansion")
    `RC5BM_ASSERT(a_no_out_unready, !w_ready |-> !o_valid, "result valid before table was ready")
    `RC5BM_ASSERT_ALWAYS(a_reset_unready, !i_rst_n |=> !w_ready, "table ready right after reset")

endmodule
